>>> hw/rtl/rcpwc_pkg.sv
// ----------------------------------------------------------------------------
// RC pulse width capture package
// Shared constants, beat types and per-channel control for the capture block.
// ----------------------------------------------------------------------------
package rcpwc_pkg;

   localparam int unsigned MAX_CHANNELS = 4;
   localparam int unsigned CHANNELS     = 4;
   localparam int unsigned TS_WIDTH     = 16;
   localparam int unsigned MIN_WIDTH_US = 1;

   typedef enum logic [0:0] {
      FUNC_SAMPLE = 1'b0,
      FUNC_READ   = 1'b1
   } func_type;

   typedef struct packed {
      func_type                    func;
      logic [MAX_CHANNELS-1:0]     pin_levels;
      logic [TS_WIDTH-1:0]         timestamp_us;
   } req_type;

   typedef struct packed {
      logic [TS_WIDTH-1:0] width_ch0;
      logic [TS_WIDTH-1:0] width_ch1;
      logic [TS_WIDTH-1:0] width_ch2;
      logic [TS_WIDTH-1:0] width_ch3;
   } rsp_type;

   typedef struct packed {
      logic sample;
      logic read;
      logic toggled;
      logic enabled;
      logic level;
   } chan_ctrl_type;

endpackage

>>> hw/rtl/rc_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// RC pulse width capture
// High-pulse width measurement on four RC receiver pins.
//
//   port group   direction  beat
//   req_         in         func, pin_levels, timestamp_us
//   rsp_         out        width_ch0 .. width_ch3 (read beats only)
//   csr_         in         channel_enable, written at once
//
// One beat per cycle unless a read beat is held; each beat is registered in the
// input register, and a read beat's result is registered in the output register.
// Reset clears levels, rise times, widths and enables all channels.
// A read beat holds in the input register while an earlier result stalls;
// sample beats never wait on the result side.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rcpwc_pkg::req_type                    req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rcpwc_pkg::rsp_type                    rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [rcpwc_pkg::MAX_CHANNELS-1:0]    csr_write_data
);

   logic                                  in_valid_ff;
   logic                                  in_valid_in;
   rcpwc_pkg::req_type                    in_item_ff;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   rcpwc_pkg::rsp_type                    rsp_item_ff;
   logic [rcpwc_pkg::MAX_CHANNELS-1:0]    levels_ff;
   logic [rcpwc_pkg::MAX_CHANNELS-1:0]    levels_in;
   logic [rcpwc_pkg::MAX_CHANNELS-1:0]    enable_ff;
   logic [rcpwc_pkg::MAX_CHANNELS-1:0]    changed;
   logic                                  is_read;
   logic                                  advance;
   logic                                  read_go;
   logic                                  sample_go;
   logic [rcpwc_pkg::MAX_CHANNELS-1:0][rcpwc_pkg::TS_WIDTH-1:0] widths;

   assign is_read   = (in_item_ff.func == rcpwc_pkg::FUNC_READ);
   assign advance   = in_valid_ff && (!is_read || !rsp_valid_ff || rsp_ready);
   assign read_go   = advance && is_read;
   assign sample_go = advance && !is_read;
   assign req_ready = !in_valid_ff || advance;
   assign changed   = in_item_ff.pin_levels ^ levels_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      levels_in = levels_ff;
      if (sample_go) begin
         levels_in = in_item_ff.pin_levels;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (read_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         levels_ff    <= '0;
         enable_ff    <= '1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         levels_ff    <= levels_in;
         if (csr_write_enable) begin
            enable_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_item_ff <= req_payload;
      end
      if (read_go) begin
         rsp_item_ff.width_ch0 <= widths[0];
         rsp_item_ff.width_ch1 <= widths[1];
         rsp_item_ff.width_ch2 <= widths[2];
         rsp_item_ff.width_ch3 <= widths[3];
      end
   end

   for (genvar i = 0; i < rcpwc_pkg::MAX_CHANNELS; i++) begin : g_chan
      if (i < rcpwc_pkg::CHANNELS) begin : g_live
         rcpwc_pkg::chan_ctrl_type ctrl;

         assign ctrl.sample  = sample_go;
         assign ctrl.read    = read_go;
         assign ctrl.toggled = changed[i];
         assign ctrl.enabled = enable_ff[i];
         assign ctrl.level   = in_item_ff.pin_levels[i];

         rcpwc_channel u_channel (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .timestamp_us (in_item_ff.timestamp_us),
            .width        (widths[i])
         );
      end else begin : g_idle
         assign widths[i] = '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

`ifndef SYNTHESIS
   a_read_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && is_read && rsp_valid_ff && !rsp_ready) |=> in_valid_ff)
      else $error("read beat dropped while result stalled");

   a_read_shows: assert property (@(posedge clock) disable iff (reset)
      read_go |=> rsp_valid)
      else $error("read beat gave no result");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      read_go |=> (widths == '0))
      else $error("widths not cleared after read");

   a_levels_hold: assert property (@(posedge clock) disable iff (reset)
      !sample_go |=> $stable(levels_ff))
      else $error("last levels moved without a sample beat");
`endif

endmodule

>>> hw/rtl/rcpwc_channel.sv
// ----------------------------------------------------------------------------
// RC pulse width capture channel
// Rise time and captured width of one receiver pin.
// ----------------------------------------------------------------------------
module rcpwc_channel (
   input  logic                             clock,
   input  logic                             reset,
   input  rcpwc_pkg::chan_ctrl_type         ctrl,
   input  logic [rcpwc_pkg::TS_WIDTH-1:0]   timestamp_us,
   output logic [rcpwc_pkg::TS_WIDTH-1:0]   width
);

   logic [rcpwc_pkg::TS_WIDTH-1:0] rise_ff;
   logic [rcpwc_pkg::TS_WIDTH-1:0] rise_in;
   logic [rcpwc_pkg::TS_WIDTH-1:0] width_ff;
   logic [rcpwc_pkg::TS_WIDTH-1:0] width_in;
   logic [rcpwc_pkg::TS_WIDTH-1:0] diff;

   assign diff = timestamp_us - rise_ff;

   always_comb begin
      rise_in  = rise_ff;
      width_in = width_ff;
      if (ctrl.read) begin
         width_in = '0;
      end else if (ctrl.sample && ctrl.toggled && ctrl.enabled) begin
         if (ctrl.level) begin
            rise_in = timestamp_us;
         end else if (diff > rcpwc_pkg::TS_WIDTH'(rcpwc_pkg::MIN_WIDTH_US)) begin
            width_in = diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff  <= '0;
         width_ff <= '0;
      end else begin
         rise_ff  <= rise_in;
         width_ff <= width_in;
      end
   end

   assign width = width_ff;

endmodule
